[src/spq_pkg.sv]
// shared types and codes for the sorted priority queue
`default_nettype none

package spq_pkg;

	localparam int VALUE_W = 32;
	localparam int FILL_W  = 5;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic                      action;
		logic signed [VALUE_W-1:0] item_value;
		logic signed [VALUE_W-1:0] item_rank;
	} in_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] head_value;
		logic signed [VALUE_W-1:0] head_rank;
		logic [FILL_W-1:0]         fill_count;
	} out_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic                      insert;
		logic                      remove;
		logic signed [VALUE_W-1:0] value;
		logic signed [VALUE_W-1:0] rank;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[src/spq_in_if.sv]
// request channel carrying insert and remove commands
`default_nettype none

interface spq_in_if;
	logic         valid;
	logic         ready;
	spq_pkg::in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/spq_out_if.sv]
// response channel carrying one result per command
`default_nettype none

interface spq_out_if;
	logic          valid;
	logic          ready;
	spq_pkg::out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/sorted_priority_queue.sv]
// sorted priority queue built as a chain of compare-and-shift cells
// the result is registered in the cycle after the command transaction
// throughput: one command per cycle while results are taken; all cells compare and shift in parallel
// a waiting result stalls new commands; one enters in the cycle the result is taken
// reset clears the entry count and the result valid flag; cell contents need no reset
`default_nettype none

module sorted_priority_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_in_if.sink    req,
	spq_out_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]                   count_q;
	logic                               res_valid_q;
	spq_pkg::out_t                      res_q;
	spq_pkg::cell_ctrl_t                ctrl;
	logic                               accept;
	logic                               do_insert;
	logic                               do_remove;
	logic                               is_full;
	logic                               is_empty;
	logic [CNT_W-1:0]                   count_next;
	logic [CNT_W+spq_pkg::FILL_W-1:0]   count_ext;

	logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
	logic signed [spq_pkg::VALUE_W-1:0] cell_rank  [DEPTH];
	logic                               cell_gt    [DEPTH];
	logic                               cell_valid [DEPTH];

	assign req.ready = !res_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign do_insert = accept && (req.data.action == spq_pkg::ACT_INSERT) && !is_full;
	assign do_remove = accept && (req.data.action == spq_pkg::ACT_REMOVE) && !is_empty;

	assign ctrl.insert = do_insert;
	assign ctrl.remove = do_remove;
	assign ctrl.value  = req.data.item_value;
	assign ctrl.rank   = req.data.item_rank;

	always_comb begin
		count_next = count_q;
		if (do_insert) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_remove) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign count_ext = {{spq_pkg::FILL_W{1'b0}}, count_next};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                               l_gt;
		logic signed [spq_pkg::VALUE_W-1:0] l_value;
		logic signed [spq_pkg::VALUE_W-1:0] l_rank;
		logic signed [spq_pkg::VALUE_W-1:0] r_value;
		logic signed [spq_pkg::VALUE_W-1:0] r_rank;

		assign cell_valid[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign l_gt    = 1'b0;
			assign l_value = ctrl.value;
			assign l_rank  = ctrl.rank;
		end else begin : g_mid
			assign l_gt    = cell_gt[i-1];
			assign l_value = cell_value[i-1];
			assign l_rank  = cell_rank[i-1];
		end

		// the tail cell refills from itself on a remove; that slot is then unused
		if (i == DEPTH - 1) begin : g_tail
			assign r_value = cell_value[i];
			assign r_rank  = cell_rank[i];
		end else begin : g_body
			assign r_value = cell_value[i+1];
			assign r_rank  = cell_rank[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.valid       (cell_valid[i]),
			.left_gt     (l_gt),
			.left_value  (l_value),
			.left_rank   (l_rank),
			.right_value (r_value),
			.right_rank  (r_rank),
			.value       (cell_value[i]),
			.rank        (cell_rank[i]),
			.gt          (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.head_value <= '0;
			res_q.head_rank  <= '0;
			res_q.fill_count <= count_ext[spq_pkg::FILL_W-1:0];
			if (req.data.action == spq_pkg::ACT_INSERT) begin
				res_q.status <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
			end else if (is_empty) begin
				res_q.status <= spq_pkg::ST_EMPTY;
			end else begin
				res_q.status     <= spq_pkg::ST_REMOVED;
				res_q.head_value <= cell_value[0];
				res_q.head_rank  <= cell_rank[0];
			end
		end
	end

	assign rsp.valid = res_valid_q;
	assign rsp.data  = res_q;

endmodule

`default_nettype wire

[src/spq_cell.sv]
// one slot of the sorted chain: holds an entry and shifts with its neighbors
`default_nettype none

module spq_cell (
	input  wire logic                               clk,
	input  wire spq_pkg::cell_ctrl_t                ctrl,
	input  wire logic                               valid,
	input  wire logic                               left_gt,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] left_value,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] left_rank,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] right_value,
	input  wire logic signed [spq_pkg::VALUE_W-1:0] right_rank,
	output logic signed [spq_pkg::VALUE_W-1:0]      value,
	output logic signed [spq_pkg::VALUE_W-1:0]      rank,
	output logic                                    gt
);

	logic signed [spq_pkg::VALUE_W-1:0] value_q;
	logic signed [spq_pkg::VALUE_W-1:0] rank_q;
	logic                               take;

	// held entry leaves first only when strictly greater, so equal ranks stay fifo
	assign gt   = valid && (rank_q > ctrl.rank);
	assign take = gt || !valid;

	always_ff @(posedge clk) begin
		if (ctrl.insert && take) begin
			if (left_gt) begin
				value_q <= left_value;
				rank_q  <= left_rank;
			end else begin
				value_q <= ctrl.value;
				rank_q  <= ctrl.rank;
			end
		end else if (ctrl.remove) begin
			value_q <= right_value;
			rank_q  <= right_rank;
		end
	end

	assign value = value_q;
	assign rank  = rank_q;

endmodule

`default_nettype wire

[tb/sorted_priority_queue_tb.sv]
// testbench for the sorted priority queue: directed and random commands against a local model
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

	localparam int DEPTH = 16;

	logic clk;
	logic arst_n;

	spq_in_if  req_if ();
	spq_out_if rsp_if ();

	sorted_priority_queue #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// commands waiting to be driven, results waiting to be seen
	spq_pkg::in_t  cmd_q[$];
	spq_pkg::out_t expected_q[$];

	// local copy of the queue contents
	logic signed [spq_pkg::VALUE_W-1:0] slot_value [DEPTH];
	logic signed [spq_pkg::VALUE_W-1:0] slot_rank [DEPTH];
	int held;

	int gen_fill;
	int gen_count;
	int errors;
	int n_inserted, n_removed, n_full, n_empty;
	int cycle_no;
	spq_pkg::out_t want;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_no <= cycle_no + 1;

	// random stall, except in a recurring quiet window
	function automatic bit take_break();
		if ((cycle_no % 1500) >= 500 && (cycle_no % 1500) < 900)
			return 1'b0;
		return $urandom_range(99) < 16;
	endfunction

	function automatic spq_pkg::out_t apply_command(spq_pkg::in_t cmd);
		spq_pkg::out_t res;
		int pos;
		res = '0;
		if (cmd.action == spq_pkg::ACT_INSERT) begin
			if (held >= DEPTH) begin
				res.status = spq_pkg::ST_FULL;
			end else begin
				// new entry goes behind every entry of equal or smaller rank
				pos = 0;
				while (pos < held && slot_rank[pos] <= cmd.item_rank)
					pos++;
				for (int i = held; i > pos; i--) begin
					slot_value[i] = slot_value[i-1];
					slot_rank[i] = slot_rank[i-1];
				end
				slot_value[pos] = cmd.item_value;
				slot_rank[pos] = cmd.item_rank;
				held++;
				res.status = spq_pkg::ST_INSERTED;
			end
		end else begin
			if (held == 0) begin
				res.status = spq_pkg::ST_EMPTY;
			end else begin
				res.head_value = slot_value[0];
				res.head_rank = slot_rank[0];
				for (int i = 1; i < held; i++) begin
					slot_value[i-1] = slot_value[i];
					slot_rank[i-1] = slot_rank[i];
				end
				held--;
				res.status = spq_pkg::ST_REMOVED;
			end
		end
		res.fill_count = held[spq_pkg::FILL_W-1:0];
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data <= '0;
		end else begin
			if (req_if.valid && req_if.ready)
				expected_q.push_back(apply_command(req_if.data));
			if (!req_if.valid || req_if.ready) begin
				if (cmd_q.size() > 0 && !take_break()) begin
					req_if.valid <= 1'b1;
					req_if.data <= cmd_q.pop_front();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no command pending: status %0d", rsp_if.data.status);
					errors++;
				end else begin
					want = expected_q.pop_front();
					compare_field("status", 32'(want.status), 32'(rsp_if.data.status));
					compare_field("head_value", want.head_value, rsp_if.data.head_value);
					compare_field("head_rank", want.head_rank, rsp_if.data.head_rank);
					compare_field("fill_count", 32'(want.fill_count),
						32'(rsp_if.data.fill_count));
					case (want.status)
						spq_pkg::ST_INSERTED: n_inserted++;
						spq_pkg::ST_REMOVED:  n_removed++;
						spq_pkg::ST_FULL:     n_full++;
						default:              n_empty++;
					endcase
				end
			end
			rsp_if.ready <= !take_break();
		end
	end

	task automatic queue_cmd(logic act, logic signed [31:0] v, logic signed [31:0] r);
		spq_pkg::in_t cmd;
		cmd.action = act;
		cmd.item_value = v;
		cmd.item_rank = r;
		cmd_q.push_back(cmd);
		if (act == spq_pkg::ACT_INSERT)
			gen_fill = (gen_fill < DEPTH) ? gen_fill + 1 : gen_fill;
		else
			gen_fill = (gen_fill > 0) ? gen_fill - 1 : 0;
		gen_count++;
	endtask

	// mostly clustered ranks so that ties are common
	function automatic logic signed [31:0] rand_rank();
		case ($urandom_range(2))
			0: return $signed($urandom_range(7)) - 4;
			1: return $urandom;
			default: begin
				case ($urandom_range(4))
					0: return 32'sh80000000;
					1: return 32'sh7fffffff;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	// waits until every queued command is sent and every result is back
	task automatic drain();
		@(negedge clk);
		while (cmd_q.size() != 0 || req_if.valid || expected_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int burst_len;
		int bias;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: underflow, extremes, ties among equal ranks and with the head
		queue_cmd(spq_pkg::ACT_REMOVE, 32'sh7fffffff, 32'sh80000000);
		queue_cmd(spq_pkg::ACT_INSERT, 32'sh7fffffff, 32'sh7fffffff);
		queue_cmd(spq_pkg::ACT_INSERT, 32'sh80000000, 32'sh80000000);
		queue_cmd(spq_pkg::ACT_INSERT, 0, 0);
		queue_cmd(spq_pkg::ACT_INSERT, -1, 0);
		queue_cmd(spq_pkg::ACT_INSERT, 1, 32'sh80000000);
		queue_cmd(spq_pkg::ACT_INSERT, 2, -1);
		queue_cmd(spq_pkg::ACT_INSERT, 3, 1);
		queue_cmd(spq_pkg::ACT_INSERT, 4, 32'sh7fffffff);
		repeat (8) queue_cmd(spq_pkg::ACT_REMOVE, $urandom, $urandom);
		queue_cmd(spq_pkg::ACT_REMOVE, -1, -1);
		drain();

		gen_count = 0;
		while (gen_count < 1000) begin
			if ($urandom_range(3) == 0) begin
				// fill past full, then empty past underflow
				repeat (DEPTH - gen_fill + $urandom_range(1, 3))
					queue_cmd(spq_pkg::ACT_INSERT, $urandom, rand_rank());
				repeat (DEPTH + $urandom_range(1, 3))
					queue_cmd(spq_pkg::ACT_REMOVE, $urandom, $urandom);
			end else begin
				burst_len = $urandom_range(20, 60);
				bias = $urandom_range(30, 70);
				repeat (burst_len)
					queue_cmd(($urandom_range(99) < bias) ?
						spq_pkg::ACT_INSERT : spq_pkg::ACT_REMOVE,
						$urandom, rand_rank());
			end
			if ($urandom_range(3) == 0)
				drain();
		end
		drain();
		repeat (6) @(posedge clk);

		$display("ran %0d commands: %0d inserts, %0d removes,",
			n_inserted + n_removed + n_full + n_empty, n_inserted, n_removed);
		$display("  %0d dropped when full, %0d underflows", n_full, n_empty);
		if (errors == 0)
			$display("sorted_priority_queue_tb: done, clean");
		else
			$display("sorted_priority_queue_tb: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d commands and %0d results outstanding",
			cmd_q.size(), expected_q.size());
		$display("sorted_priority_queue_tb: done, errors");
		$finish;
	end

endmodule
